>>> rtl/assert_macros.svh
// assertion helpers shared by crf_raster and the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/crf_pkg.sv
package crf_pkg;

    // item kind carried on s_tuser
    typedef enum logic {
        KIND_DRAW = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    // operation held in the write-back stage
    typedef enum logic {
        OP_SET  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // top level control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ
    } ctrl_state_t;

    // decision variable constants of the Bresenham circle rule
    localparam int D_INIT      = 3;
    localparam int D_STEP_LOW  = 6;
    localparam int D_STEP_HIGH = 10;

    // single pixel bit within a page byte
    localparam logic [7:0] PIXEL_ONE = 8'h01;

    // draw command handed to the rasterizer
    typedef struct packed {
        logic [6:0] cx;
        logic [5:0] cy;
        logic [6:0] radius;
        logic       solid;
    } draw_cmd_t;

    // one candidate point, signed so off-panel points are visible
    typedef struct packed {
        logic              valid;
        logic signed [9:0] px;
        logic signed [9:0] py;
    } point_t;

endpackage

>>> rtl/crf_ram.sv
module crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read returning the old contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/crf_raster.sv
`include "assert_macros.svh"

module crf_raster (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  crf_pkg::draw_cmd_t cmd,
    output crf_pkg::point_t    point,
    output logic               busy
);

    import crf_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [6:0]        cx_reg;
    logic [5:0]        cy_reg;
    logic              solid_reg;
    logic signed [8:0] x_reg;
    logic signed [8:0] x_next;
    logic signed [8:0] y_reg;
    logic signed [8:0] y_next;
    logic signed [8:0] span_reg;
    logic signed [11:0] d_reg;
    logic signed [11:0] d_next;
    logic signed [11:0] x_wide;
    logic signed [11:0] y_wide;
    logic [2:0]        oct_reg;
    logic signed [8:0] b_sel;
    logic signed [8:0] u_off;
    logic signed [8:0] v_off;
    logic signed [9:0] cx_s;
    logic signed [9:0] cy_s;
    logic              step_span;

    // octant offsets: first four use (x, b), last four swap them
    assign b_sel = solid_reg ? span_reg : y_reg;
    assign u_off = oct_reg[2] ? b_sel : x_reg;
    assign v_off = oct_reg[2] ? x_reg : b_sel;
    assign cx_s  = $signed({3'b000, cx_reg});
    assign cy_s  = $signed({4'b0000, cy_reg});

    // point for the current octant
    always_comb begin
        point.valid = busy_reg;
        point.px    = oct_reg[0] ? (cx_s - {u_off[8], u_off}) : (cx_s + {u_off[8], u_off});
        point.py    = oct_reg[1] ? (cy_s - {v_off[8], v_off}) : (cy_s + {v_off[8], v_off});
    end

    // Bresenham circle decision step
    assign x_wide    = {{3{x_reg[8]}}, x_reg};
    assign y_wide    = {{3{y_reg[8]}}, y_reg};
    assign step_span = solid_reg && (span_reg < y_reg);
    assign x_next    = x_reg + 9'sd1;

    always_comb begin
        if (d_reg < 12'sd0) begin
            d_next = d_reg + (x_wide <<< 2) + 12'(D_STEP_LOW);
            y_next = y_reg;
        end else begin
            d_next = d_reg + ((x_wide - y_wide) <<< 2) + 12'(D_STEP_HIGH);
            y_next = y_reg - 9'sd1;
        end
        busy_next = (x_next <= y_next);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            oct_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            oct_reg  <= '0;
        end else if (busy_reg) begin
            oct_reg <= oct_reg + 3'd1;
            if ((oct_reg == 3'd7) && !step_span) begin
                busy_reg <= busy_next;
            end
        end
    end

    // walk state
    always_ff @(posedge aclk) begin
        if (start) begin
            cx_reg    <= cmd.cx;
            cy_reg    <= cmd.cy;
            solid_reg <= cmd.solid;
            x_reg     <= '0;
            y_reg     <= $signed({2'b00, cmd.radius});
            span_reg  <= '0;
            d_reg     <= 12'(D_INIT) - $signed({4'b0000, cmd.radius, 1'b0});
        end else if (busy_reg && (oct_reg == 3'd7)) begin
            if (step_span) begin
                span_reg <= span_reg + 9'sd1;
            end else begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                d_reg    <= d_next;
                span_reg <= x_next;
            end
        end
    end

    assign busy = busy_reg;

    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg)
    `ASSERT_IMPLIES(a_walk_bounds, aclk, aresetn, busy_reg, (x_reg <= y_reg) && (!solid_reg || (span_reg >= x_reg && span_reg <= y_reg)))

endmodule

>>> rtl/circle_rasterizer_framebuffer_top.sv
// Circle rasterizer over a page-organized monochrome framebuffer.
// Input channel s_*: one transfer is a draw item (s_tuser 0) or a read item
// (s_tuser 1). A draw sets the pixels of a Bresenham circle, outline or filled,
// and produces no result. A read returns the byte at (column, page) on the
// m_* channel and clears it; an out-of-panel address returns 0.
// Framebuffer: COLUMNS*PAGES bytes in one RAM with a registered read,
// updated by read-modify-write with forwarding between adjacent accesses.
// Operation: a draw walks N octant steps (x values, times span values when
// filled), eight candidate points per step, with one RAM access per point on
// the panel. A read issues its access once the output register is free or
// being taken. No new item is accepted until the current one is issued.
// Reset: the control clears and a sweep writes zeros to every byte, during
// which s_tready stays low.
// Stall: the result sits in an output register; further items, draws and
// reads, are accepted while it waits, and a following read holds in the read
// state while the previous result remains untaken.
`include "assert_macros.svh"

module circle_rasterizer_framebuffer_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // center_x[6:0], center_y[12:7], radius[19:13], fill[20],
    // read_column[27:21], read_page[30:28], zero[31]
    input  logic [31:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_byte[7:0]
    output logic [7:0]  m_tdata
);

    import crf_pkg::*;

    localparam int ROWS  = PAGES * 8;
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic          s_accept;
    logic          rd_accept;
    logic          slot_free;
    logic [6:0]    rd_col_reg;
    logic [2:0]    rd_page_reg;
    logic          rd_in_range;
    logic [AW-1:0] rd_addr_calc;
    logic [AW-1:0] clr_addr_reg;

    draw_cmd_t     cmd;
    point_t        point;
    logic          raster_start;
    logic          raster_busy;
    logic          pt_in_range;
    logic [AW-1:0] pt_addr;

    logic          issue_valid;
    op_t           issue_op;
    logic          issue_write;
    logic [AW-1:0] issue_addr;
    logic [7:0]    issue_mask;

    logic          p1_valid_reg;
    op_t           p1_op_reg;
    logic          p1_write_reg;
    logic [AW-1:0] p1_addr_reg;
    logic [7:0]    p1_mask_reg;
    logic          p1_read;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic [7:0]    ram_rd_data;
    logic [7:0]    merged;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;

    logic          m_valid_reg;
    logic [7:0]    m_data_reg;

    assign s_accept  = s_tvalid && s_tready;
    assign rd_accept = s_accept && (kind_t'(s_tuser) == KIND_READ);
    assign slot_free = !m_valid_reg || m_tready;

    // draw command fields
    assign cmd.cx     = s_tdata[6:0];
    assign cmd.cy     = s_tdata[12:7];
    assign cmd.radius = s_tdata[19:13];
    assign cmd.solid  = s_tdata[20];
    assign raster_start = s_accept && (kind_t'(s_tuser) == KIND_DRAW);

    crf_raster u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (raster_start),
        .cmd     (cmd),
        .point   (point),
        .busy    (raster_busy)
    );

    // panel clipping and byte address of the current point
    assign pt_in_range = point.valid && (point.px >= 10'sd0) && (point.px < COLUMNS)
                         && (point.py >= 10'sd0) && (point.py < ROWS);
    assign pt_addr = AW'(point.px[8:0]) * AW'(PAGES) + AW'(point.py[8:3]);

    // read item address
    assign rd_in_range  = (rd_col_reg < COLUMNS) && (rd_page_reg < PAGES);
    assign rd_addr_calc = AW'(rd_col_reg) * AW'(PAGES) + AW'(rd_page_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (kind_t'(s_tuser) == KIND_READ) ? ST_READ : ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (!raster_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the control: handshake and memory access issue
    always_comb begin
        s_tready    = 1'b0;
        issue_valid = 1'b0;
        issue_op    = OP_SET;
        issue_write = 1'b0;
        issue_addr  = pt_addr;
        issue_mask  = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                s_tready = 1'b0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_DRAW: begin
                if (pt_in_range) begin
                    issue_valid = 1'b1;
                    issue_write = 1'b1;
                    issue_mask  = PIXEL_ONE << point.py[2:0];
                end
            end
            ST_READ: begin
                issue_addr = rd_addr_calc;
                if (slot_free) begin
                    issue_valid = 1'b1;
                    issue_op    = OP_READ;
                    issue_write = rd_in_range;
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    // state, clear sweep and read address capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_col_reg  <= s_tdata[27:21];
            rd_page_reg <= s_tdata[30:28];
        end
    end

    // write-back stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge aclk) begin
        p1_op_reg    <= issue_op;
        p1_write_reg <= issue_write;
        p1_addr_reg  <= issue_addr;
        p1_mask_reg  <= issue_mask;
    end

    assign p1_read = p1_valid_reg && (p1_op_reg == OP_READ);

    // forward the byte written in the same cycle as a read of that byte
    assign merged = fwd_reg ? fwd_data_reg : ram_rd_data;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = p1_valid_reg && p1_write_reg;
            ram_wr_addr = p1_addr_reg;
            ram_wr_data = (p1_op_reg == OP_SET) ? (merged | p1_mask_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= ram_wr_en && (ram_wr_addr == issue_addr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wr_data;
    end

    crf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (issue_addr),
        .rd_data (ram_rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_read) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_read) begin
            m_data_reg <= p1_write_reg ? merged : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_IMPLIES(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready)
    `ASSERT_IMPLIES(a_no_wb_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !p1_valid_reg)
    `ASSERT_IMPLIES(a_read_slot_free, aclk, aresetn, p1_read, !m_valid_reg)
    `ASSERT_IMPLIES(a_raster_in_draw, aclk, aresetn, raster_busy, state_reg == ST_DRAW)
    `ASSERT_NEXT(a_read_enters_read, aclk, aresetn, rd_accept, state_reg == ST_READ)

endmodule
